[src/acri_pkg.sv]
// shared types, constants and fixed-point helpers for the collide/resolve/integrate block
// no dependencies
`timescale 1ns / 1ps

package acri_pkg;

	localparam int MAX_COLLIDERS = 64;
	localparam int AW = (MAX_COLLIDERS > 1) ? $clog2(MAX_COLLIDERS) : 1;
	localparam int CW = $clog2(MAX_COLLIDERS + 1);
	localparam logic signed [16:0] DAMP_Q16 = 17'sd52429;

	localparam logic [1:0] CFG_GRAVITY  = 2'd0;
	localparam logic [1:0] CFG_DRAG     = 2'd1;
	localparam logic [1:0] CFG_FRICTION = 2'd2;
	localparam logic [1:0] CFG_COUNT    = 2'd3;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [30:0]        w;
		logic [30:0]        h;
		logic [15:0]        tag;
	} box_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_WALK, ST_DRAIN, ST_MULS, ST_ADD, ST_DRAG,
		ST_SUB, ST_FRIC, ST_POS, ST_OUT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_START, OP_MULS, OP_ADD, OP_DRAG, OP_SUB, OP_FRIC, OP_POS, OP_OUT
	} op_t;

	typedef struct packed {
		op_t           op;
		logic          wr_en;
		logic          rd_en;
		logic [AW-1:0] rd_addr;
	} cmd_t;

	typedef struct packed {
		logic          pipe_busy;
		logic          out_free;
		logic [CW-1:0] walk_n;
	} sts_t;

	function automatic logic signed [35:0] sx36(input logic signed [31:0] a);
		return {{4{a[31]}}, a};
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		if (v > 36'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -36'sd2147483648)
			return 32'sh80000000;
		else
			return v[31:0];
	endfunction

	// exact product, floor shift by 16, saturate
	function automatic logic signed [31:0] mul_q16(input logic signed [32:0] a,
			input logic signed [16:0] b);
		logic signed [49:0] p;
		p = a * b;
		return sat32({{2{p[49]}}, p[49:16]});
	endfunction

endpackage

[src/aabb_collide_resolve_integrate.sv]
// top level of the box collide, resolve and integrate block
// depends on acri_pkg, acri_ctrl, acri_datapath (which holds acri_ram)
`timescale 1ns / 1ps

// A load request (kind 0) writes one collider box into table slot "slot" in the
// cycle it is accepted and returns no result. A mover request (kind 1) walks the
// first n = min(collider_count, 64) table entries, one entry per cycle through the
// table's single registered read port, waits for the overlap pipeline to drain, then
// runs the multiply, add, drag, subtract, friction and position update steps and an
// output step that waits until the output register is free; one request is worked
// at a time. The finished result sits in an output register, so the next request
// can be taken in the cycle after the result is written, while it waits. Config
// writes are taken any cycle but belong to idle periods. Table slots never loaded
// read as garbage.

module aabb_collide_resolve_integrate (
	input  logic               clk,
	input  logic               arst_n,
	// config write port
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	// request channel
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [5:0]         slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        box_width,
	input  logic [30:0]        box_height,
	input  logic [15:0]        tag,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] acc_x,
	input  logic signed [31:0] acc_y,
	input  logic [15:0]        frame_time,
	// result channel
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_acc_x,
	output logic signed [31:0] new_acc_y,
	output logic               grounded
);
	import acri_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller: walk counter and step sequencing
	acri_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: table, overlap pipeline, integrator, output register
	acri_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.sts        (sts),
		.slot       (slot),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.box_width  (box_width),
		.box_height (box_height),
		.tag        (tag),
		.vel_x      (vel_x),
		.vel_y      (vel_y),
		.acc_x      (acc_x),
		.acc_y      (acc_y),
		.frame_time (frame_time),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.new_pos_x  (new_pos_x),
		.new_pos_y  (new_pos_y),
		.new_vel_x  (new_vel_x),
		.new_vel_y  (new_vel_y),
		.new_acc_x  (new_acc_x),
		.new_acc_y  (new_acc_y),
		.grounded   (grounded)
	);

`ifndef SYNTHESIS
	// a mover request makes the block busy on the next cycle
	a_mover_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind) |=> !in_ready)
		else $error("request taken right after a mover");

	// table reads happen only while a mover is in work
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ready)
		else $error("table read while idle");

	// a new result appears only from the output step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.op == OP_OUT))
		else $error("result without output step");
`endif

endmodule

[src/acri_ram.sv]
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module acri_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic                                         re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

[src/acri_ctrl.sv]
// controller: sequences table walk and velocity update steps
// depends on acri_pkg
`timescale 1ns / 1ps

module acri_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          kind,
	input  acri_pkg::sts_t sts,
	output acri_pkg::cmd_t cmd
);
	import acri_pkg::*;

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		in_ready    = 1'b0;
		cmd.op      = OP_NONE;
		cmd.wr_en   = 1'b0;
		cmd.rd_en   = 1'b0;
		cmd.rd_addr = cnt_q[AW-1:0];
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cnt_d    = '0;
				if (in_valid && !kind)
					cmd.wr_en = 1'b1;
				else if (in_valid) begin
					cmd.op  = OP_START;
					state_d = (sts.walk_n == '0) ? ST_MULS : ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.rd_en = 1'b1;
				if (cnt_q == sts.walk_n - CW'(1))
					state_d = ST_DRAIN;
				else
					cnt_d = cnt_q + CW'(1);
			end
			ST_DRAIN: if (!sts.pipe_busy) state_d = ST_MULS;
			ST_MULS: begin cmd.op = OP_MULS; state_d = ST_ADD;  end
			ST_ADD:  begin cmd.op = OP_ADD;  state_d = ST_DRAG; end
			ST_DRAG: begin cmd.op = OP_DRAG; state_d = ST_SUB;  end
			ST_SUB:  begin cmd.op = OP_SUB;  state_d = ST_FRIC; end
			ST_FRIC: begin cmd.op = OP_FRIC; state_d = ST_POS;  end
			ST_POS:  begin cmd.op = OP_POS;  state_d = ST_OUT;  end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.op  = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

[src/acri_datapath.sv]
// datapath: config registers, collider table, overlap pipeline, integration and output register
// depends on acri_pkg and acri_ram
`timescale 1ns / 1ps

module acri_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [1:0]         cfg_index,
	input  logic [30:0]        cfg_data,
	input  acri_pkg::cmd_t     cmd,
	output acri_pkg::sts_t     sts,
	input  logic [5:0]         slot,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic [30:0]        box_width,
	input  logic [30:0]        box_height,
	input  logic [15:0]        tag,
	input  logic signed [31:0] vel_x,
	input  logic signed [31:0] vel_y,
	input  logic signed [31:0] acc_x,
	input  logic signed [31:0] acc_y,
	input  logic [15:0]        frame_time,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] new_pos_x,
	output logic signed [31:0] new_pos_y,
	output logic signed [31:0] new_vel_x,
	output logic signed [31:0] new_vel_y,
	output logic signed [31:0] new_acc_x,
	output logic signed [31:0] new_acc_y,
	output logic               grounded
);
	import acri_pkg::*;

	logic [30:0] gravity_q, friction_q;
	logic [15:0] drag_q;
	logic [6:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gravity_q  <= '0;
			drag_q     <= '0;
			friction_q <= '0;
			count_q    <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_GRAVITY:  gravity_q  <= cfg_data;
				CFG_DRAG:     drag_q     <= cfg_data[15:0];
				CFG_FRICTION: friction_q <= cfg_data;
				CFG_COUNT:    count_q    <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign sts.walk_n = (32'(count_q) > MAX_COLLIDERS) ? CW'(MAX_COLLIDERS) : CW'(count_q);

	// collider table
	box_t wbox, rbox;
	logic wr_ok;
	assign wbox  = '{x: pos_x, y: pos_y, w: box_width, h: box_height, tag: tag};
	assign wr_ok = cmd.wr_en && (32'(slot) < MAX_COLLIDERS);

	acri_ram #(.WIDTH($bits(box_t)), .DEPTH(MAX_COLLIDERS)) u_table (
		.clk   (clk),
		.we    (wr_ok),
		.waddr (AW'(slot)),
		.wdata (wbox),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rbox)
	);

	// mover state
	logic signed [31:0] px0_q, py0_q, px_q, py_q, vx_q, vy_q, ax_q, ay_q;
	logic [30:0]        w_q, h_q;
	logic [15:0]        tag_q, dt_q;
	logic               gnd_q;
	logic signed [31:0] grav_q, fric_q, prod_x_q, prod_y_q;

	// pipeline valid bits
	logic rd_v_q, s1_v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_q <= 1'b0;
			s1_v_q <= 1'b0;
		end else begin
			rd_v_q <= cmd.rd_en;
			s1_v_q <= rd_v_q;
		end
	end
	assign sts.pipe_busy = rd_v_q | s1_v_q;

	// overlap geometry at doubled scale
	logic signed [35:0] cx1, cx2, dx, adx, ox, cy1, cy2, dy, ady, oy, mx, my;
	always_comb begin
		cx1 = $signed({{3{px0_q[31]}}, px0_q, 1'b0}) + $signed({5'd0, w_q});
		cx2 = $signed({{3{rbox.x[31]}}, rbox.x, 1'b0}) + $signed({5'd0, rbox.w});
		dx  = cx1 - cx2;
		adx = dx[35] ? -dx : dx;
		ox  = $signed({5'd0, w_q}) + $signed({5'd0, rbox.w}) - adx;
		cy1 = $signed({{3{py0_q[31]}}, py0_q, 1'b0}) + $signed({5'd0, h_q});
		cy2 = $signed({{3{rbox.y[31]}}, rbox.y, 1'b0}) + $signed({5'd0, rbox.h});
		dy  = cy1 - cy2;
		ady = dy[35] ? -dy : dy;
		oy  = $signed({5'd0, h_q}) + $signed({5'd0, rbox.h}) - ady;
		mx  = (ox + 36'sd1) >>> 1;
		my  = (oy + 36'sd1) >>> 1;
	end

	logic        hit_s1, xaxis_s1, neg_s1;
	logic [32:0] m_s1;
	always_ff @(posedge clk) begin
		if (rd_v_q) begin
			hit_s1   <= (rbox.tag != tag_q) && (ox > 36'sd0) && (oy > 36'sd0);
			xaxis_s1 <= ox < oy;
			neg_s1   <= (ox < oy) ? (px0_q < rbox.x) : (py0_q < rbox.y);
			m_s1     <= (ox < oy) ? mx[32:0] : my[32:0];
		end
	end

	logic signed [35:0] msx;
	logic signed [31:0] ygrav, fric_vx;
	logic [32:0]        avx;
	assign msx   = $signed({3'd0, m_s1});
	assign ygrav = gnd_q ? vy_q : sat32(sx36(vy_q) + sx36(grav_q));
	assign avx   = vx_q[31] ? -{vx_q[31], vx_q} : {1'b0, vx_q};

	always_comb begin
		if (avx < {1'b0, fric_q})
			fric_vx = '0;
		else if (!vx_q[31])
			fric_vx = vx_q - fric_q;
		else
			fric_vx = vx_q + fric_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gnd_q <= 1'b0;
		else if (cmd.op == OP_START)
			gnd_q <= 1'b0;
		else if (s1_v_q && hit_s1 && !xaxis_s1 && neg_s1)
			gnd_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_START: begin
				px0_q <= pos_x;  py0_q <= pos_y;
				px_q  <= pos_x;  py_q  <= pos_y;
				w_q   <= box_width; h_q <= box_height;
				tag_q <= tag;    dt_q  <= frame_time;
				vx_q  <= vel_x;  vy_q  <= vel_y;
				ax_q  <= acc_x;  ay_q  <= acc_y;
			end
			OP_MULS: begin
				grav_q   <= mul_q16({2'b00, gravity_q}, {1'b0, dt_q});
				fric_q   <= mul_q16({2'b00, friction_q}, {1'b0, dt_q});
				prod_x_q <= mul_q16({ax_q[31], ax_q}, {1'b0, dt_q});
				prod_y_q <= mul_q16({ay_q[31], ay_q}, {1'b0, dt_q});
			end
			OP_ADD: begin
				vy_q <= sat32(sx36(ygrav) - sx36(prod_y_q));
				vx_q <= sat32(sx36(vx_q) + sx36(prod_x_q));
			end
			OP_DRAG: begin
				prod_x_q <= mul_q16({vx_q[31], vx_q}, {1'b0, drag_q});
				prod_y_q <= mul_q16({vy_q[31], vy_q}, {1'b0, drag_q});
			end
			OP_SUB: begin
				vx_q <= sat32(sx36(vx_q) - sx36(prod_x_q));
				vy_q <= sat32(sx36(vy_q) - sx36(prod_y_q));
			end
			OP_FRIC: begin
				if (gnd_q)
					vx_q <= fric_vx;
				py_q <= sat32(sx36(py_q) + sx36(vy_q));
			end
			OP_POS: px_q <= sat32(sx36(px_q) + sx36(vx_q));
			default: begin
				if (s1_v_q && hit_s1) begin
					if (xaxis_s1) begin
						px_q <= sat32(neg_s1 ? sx36(px_q) - msx : sx36(px_q) + msx);
						vx_q <= mul_q16({vx_q[31], vx_q}, DAMP_Q16);
						ax_q <= '0;
					end else begin
						py_q <= sat32(neg_s1 ? sx36(py_q) - msx : sx36(py_q) + msx);
						vy_q <= mul_q16({vy_q[31], vy_q}, DAMP_Q16);
						ay_q <= '0;
					end
				end
			end
		endcase
	end

	// output register
	assign sts.out_free = !out_valid || out_ready;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (cmd.op == OP_OUT)
			out_valid <= 1'b1;
		else if (out_ready)
			out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_OUT) begin
			new_pos_x <= px_q;
			new_pos_y <= py_q;
			new_vel_x <= vx_q;
			new_vel_y <= vy_q;
			new_acc_x <= ax_q;
			new_acc_y <= ay_q;
			grounded  <= gnd_q;
		end
	end

endmodule

[test/tb_top.sv]
// self-checking testbench for aabb_collide_resolve_integrate: directed table then random phases
// depends on acri_pkg and the block's RTL; keeps its own collision and integration predictor
`timescale 1ns / 1ps

module tb_top;
	import acri_pkg::*;

	localparam int Q1 = 65536;
	localparam int MAX_CYCLES = 3000000;
	localparam int DRAIN_CYCLES = 90;  // one full 64-entry walk plus the update tail

	typedef struct packed {
		logic               kind;
		logic [5:0]         slot;
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [30:0]        w;
		logic [30:0]        h;
		logic [15:0]        tag;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic [15:0]        dt;
	} req_t;

	typedef struct packed {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic               gnd;
	} motion_t;

	typedef enum int {ROW_LOAD, ROW_MOVE, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t  rk;
		req_t       req;
		logic [1:0] cfg_idx;
		logic [30:0] cfg_val;
		bit         has_exp;
		motion_t    exp;
	} row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_wr_en = 0;
	logic [1:0]         cfg_index = '0;
	logic [30:0]        cfg_data = '0;
	logic               in_valid = 0;
	logic               in_ready;
	logic               kind = 0;
	logic [5:0]         slot = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0;
	logic [30:0]        box_width = '0, box_height = '0;
	logic [15:0]        tag = '0;
	logic signed [31:0] vel_x = '0, vel_y = '0, acc_x = '0, acc_y = '0;
	logic [15:0]        frame_time = '0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [31:0] new_pos_x, new_pos_y, new_vel_x, new_vel_y, new_acc_x, new_acc_y;
	logic               grounded;

	aabb_collide_resolve_integrate dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(kind), .slot(slot), .pos_x(pos_x), .pos_y(pos_y),
		.box_width(box_width), .box_height(box_height), .tag(tag),
		.vel_x(vel_x), .vel_y(vel_y), .acc_x(acc_x), .acc_y(acc_y),
		.frame_time(frame_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.new_pos_x(new_pos_x), .new_pos_y(new_pos_y),
		.new_vel_x(new_vel_x), .new_vel_y(new_vel_y),
		.new_acc_x(new_acc_x), .new_acc_y(new_acc_y),
		.grounded(grounded)
	);

	always #5 clk = ~clk;

	// predictor copy of the collider table and the global registers
	longint      box_x[MAX_COLLIDERS], box_y[MAX_COLLIDERS];
	longint      box_w[MAX_COLLIDERS], box_h[MAX_COLLIDERS];
	logic [15:0] box_tag[MAX_COLLIDERS];
	longint      gravity_q, drag_q, friction_q;
	int          walk_count;

	motion_t     motion_q[$];   // results still owed by the block
	int          errors = 0;
	int          cycle_cnt = 0;
	int          stall_mode = 0; // 0 always ready, 1 fixed pattern, 2 random
	bit          bursty = 0;
	int          burst_left = 0;
	row_t        rows[$];

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	// exact product, floor toward minus infinity, saturate
	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> 16);
	endfunction

	function automatic longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic motion_t predict_motion(req_t r);
		longint  px0, py0, w, h, vx, vy, ax, ay, dt, px, py;
		longint  x2, y2, w2, h2, ox, oy, m, f;
		int      n;
		bit      gnd;
		motion_t res;
		px0 = longint'(r.px); py0 = longint'(r.py);
		w = longint'(r.w); h = longint'(r.h);
		vx = longint'(r.vx); vy = longint'(r.vy);
		ax = longint'(r.ax); ay = longint'(r.ay);
		dt = longint'(r.dt);
		px = px0; py = py0; gnd = 0;
		n = (walk_count > MAX_COLLIDERS) ? MAX_COLLIDERS : walk_count;
		for (int i = 0; i < n; i++) begin
			x2 = box_x[i]; y2 = box_y[i]; w2 = box_w[i]; h2 = box_h[i];
			if (box_tag[i] == r.tag)
				continue;
			// overlaps at doubled scale from center distance
			ox = (w + w2) - mag((2 * px0 + w) - (2 * x2 + w2));
			if (ox <= 0)
				continue;
			oy = (h + h2) - mag((2 * py0 + h) - (2 * y2 + h2));
			if (oy <= 0)
				continue;
			if (ox < oy) begin
				m = (ox + 1) >>> 1;
				px = clamp32((px0 < x2) ? px - m : px + m);
				vx = qmul(vx, DAMP_Q16);
				ax = 0;
			end else begin
				m = (oy + 1) >>> 1;
				if (py0 < y2) begin
					py = clamp32(py - m);
					gnd = 1;
				end else begin
					py = clamp32(py + m);
				end
				vy = qmul(vy, DAMP_Q16);
				ay = 0;
			end
		end
		if (!gnd)
			vy = clamp32(vy + qmul(gravity_q, dt));
		vy = clamp32(vy - qmul(ay, dt));
		vy = clamp32(vy - qmul(vy, drag_q));
		vx = clamp32(vx + qmul(ax, dt));
		vx = clamp32(vx - qmul(vx, drag_q));
		if (gnd) begin
			// ground friction pulls toward zero and never overshoots
			f = qmul(friction_q, dt);
			if (mag(vx) < f)
				vx = 0;
			else if (vx >= 0)
				vx = vx - f;
			else
				vx = vx + f;
		end
		px = clamp32(px + vx);
		py = clamp32(py + vy);
		res.px = px[31:0]; res.py = py[31:0];
		res.vx = vx[31:0]; res.vy = vy[31:0];
		res.ax = ax[31:0]; res.ay = ay[31:0];
		res.gnd = gnd;
		return res;
	endfunction

	function automatic req_t mk_move(int x, int y, int w, int h, int t, int vx, int vy,
			int ax, int ay, int dt);
		req_t r;
		r.kind = 1'b1; r.slot = '0;
		r.px = x; r.py = y; r.w = 31'(w); r.h = 31'(h); r.tag = 16'(t);
		r.vx = vx; r.vy = vy; r.ax = ax; r.ay = ay; r.dt = 16'(dt);
		return r;
	endfunction

	function automatic req_t mk_load(int s, int x, int y, int w, int h, int t);
		req_t r;
		r = mk_move(x, y, w, h, t, 0, 0, 0, 0, 0);
		r.kind = 1'b0; r.slot = 6'(s);
		return r;
	endfunction

	// drive one request and hold it until taken; predict at the accepting edge
	task automatic send_request(req_t r, bit has_exp, motion_t fixed);
		in_valid <= 1;
		kind <= r.kind; slot <= r.slot; pos_x <= r.px; pos_y <= r.py;
		box_width <= r.w; box_height <= r.h; tag <= r.tag;
		vel_x <= r.vx; vel_y <= r.vy; acc_x <= r.ax; acc_y <= r.ay;
		frame_time <= r.dt;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (r.kind == 0) begin
			box_x[r.slot] = longint'(r.px); box_y[r.slot] = longint'(r.py);
			box_w[r.slot] = longint'(r.w); box_h[r.slot] = longint'(r.h);
			box_tag[r.slot] = r.tag;
		end else begin
			motion_q.insert(motion_q.size(), has_exp ? fixed : predict_motion(r));
		end
		// sender works in bursts with random gaps
		if (bursty) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				in_valid <= 0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
				burst_left = $urandom_range(0, 12);
			end
		end
	endtask

	// stop sending and wait for every owed result, then for the block to go quiet
	task automatic drain_idle();
		in_valid <= 0;
		while (motion_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic model_reg(logic [1:0] idx, logic [30:0] val);
		case (idx)
		CFG_GRAVITY: begin
			gravity_q = longint'(val);
		end
		CFG_DRAG: begin
			drag_q = longint'(val[15:0]);
		end
		CFG_FRICTION: begin
			friction_q = longint'(val);
		end
		CFG_COUNT: begin
			walk_count = int'(val[6:0]);
		end
		endcase
	endtask

	// four back-to-back register writes, enable lowered once at the end
	task automatic write_globals(logic [30:0] g, logic [30:0] d, logic [30:0] f, logic [30:0] c);
		logic [30:0] vals[4];
		logic [1:0]  idxs[4];
		vals = '{g, d, f, c};
		idxs = '{CFG_GRAVITY, CFG_DRAG, CFG_FRICTION, CFG_COUNT};
		for (int i = 0; i < 4; i++) begin
			cfg_wr_en <= 1; cfg_index <= idxs[i]; cfg_data <= vals[i];
			@(posedge clk);
			model_reg(idxs[i], vals[i]);
		end
		cfg_wr_en <= 0;
	endtask

	function automatic int near(int center, int spread);
		return center + int'($urandom_range(0, 2 * spread)) - spread;
	endfunction

	function automatic req_t rand_collider(int s, int cx, int cy);
		req_t r;
		r = mk_load(s, near(cx, 24 * Q1), near(cy, 24 * Q1),
			$urandom_range(0, 10 * Q1), $urandom_range(0, 10 * Q1), $urandom_range(0, 7));
		if ($urandom_range(0, 15) == 0) begin
			r.w = 31'($urandom); r.h = 31'($urandom); r.tag = 16'($urandom);
		end
		// the ignored motion fields still get toggled
		r.vx = $urandom; r.vy = $urandom; r.ax = $urandom; r.ay = $urandom;
		r.dt = 16'($urandom);
		return r;
	endfunction

	function automatic req_t rand_mover(int cx, int cy);
		req_t r;
		r.kind = 1'b1; r.slot = 6'($urandom);
		if ($urandom_range(0, 99) < 80) begin
			// aimed into the collider cluster so pushes happen
			r.px = near(cx, 26 * Q1); r.py = near(cy, 26 * Q1);
			r.w = 31'($urandom_range(0, 8 * Q1)); r.h = 31'($urandom_range(0, 8 * Q1));
			r.tag = 16'($urandom_range(0, 9));
			r.vx = near(0, 8 * Q1); r.vy = near(0, 8 * Q1);
			r.ax = near(0, 4 * Q1); r.ay = near(0, 4 * Q1);
			r.dt = 16'($urandom);
		end else begin
			r.px = $urandom; r.py = $urandom; r.w = 31'($urandom); r.h = 31'($urandom);
			r.tag = 16'($urandom); r.vx = $urandom; r.vy = $urandom;
			r.ax = $urandom; r.ay = $urandom; r.dt = 16'($urandom);
		end
		return r;
	endfunction

	// result side: stall pattern, compare, watchdog
	always @(posedge clk) begin
		motion_t e;
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > MAX_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end else begin
			case (stall_mode)
			0: out_ready <= 1;
			1: out_ready <= (cycle_cnt % 7) >= 3;
			default: out_ready <= 1'($urandom_range(0, 1));
			endcase
			if (out_valid && out_ready) begin
				if (motion_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected result at cycle %0d", cycle_cnt);
				end else begin
					e = motion_q.pop_front();
					if (new_pos_x !== e.px || new_pos_y !== e.py || new_vel_x !== e.vx ||
							new_vel_y !== e.vy || new_acc_x !== e.ax || new_acc_y !== e.ay ||
							grounded !== e.gnd) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at cycle %0d", cycle_cnt);
							$display("  exp pos %h %h vel %h %h acc %h %h gnd %b",
								e.px, e.py, e.vx, e.vy, e.ax, e.ay, e.gnd);
							$display("  got pos %h %h vel %h %h acc %h %h gnd %b",
								new_pos_x, new_pos_y, new_vel_x, new_vel_y,
								new_acc_x, new_acc_y, grounded);
						end
					end
				end
			end
		end
	end

	task automatic add_row(row_kind_t rk, req_t r, bit has_exp, motion_t e);
		row_t x;
		x.rk = rk; x.req = r; x.has_exp = has_exp; x.exp = e;
		x.cfg_idx = '0; x.cfg_val = '0;
		rows.insert(rows.size(), x);
	endtask

	task automatic add_cfg(logic [1:0] idx, logic [30:0] val);
		row_t x;
		x.rk = ROW_CFG; x.req = '0; x.has_exp = 0; x.exp = '0;
		x.cfg_idx = idx; x.cfg_val = val;
		rows.insert(rows.size(), x);
	endtask

	initial begin
		localparam int MAXP = 32'h7fffffff;
		localparam int MINN = 32'h80000000;
		motion_t none, e;
		req_t    r;
		int      cx, cy;
		logic [30:0] g, d, f, c;

		none = '0;
		gravity_q = 0; drag_q = 0; friction_q = 0; walk_count = 0;
		for (int i = 0; i < MAX_COLLIDERS; i++) begin
			box_x[i] = 0; box_y[i] = 0; box_w[i] = 0; box_h[i] = 0;
			box_tag[i] = 0;
		end

		// directed table; reset globals leave a mover untouched except pos += vel
		add_row(ROW_MOVE, mk_move(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, none);
		e = '{MAXP, MAXP, MAXP, MAXP, MINN, MAXP, 1'b0};
		add_row(ROW_MOVE, mk_move(MAXP, MAXP, MAXP, MAXP, 16'hffff, MAXP, MAXP, MINN, MAXP, 0),
			1, e);
		e = '{MINN, MINN, MINN, MINN, MAXP, MINN, 1'b0};
		add_row(ROW_MOVE, mk_move(MINN, MINN, 0, 0, 0, MINN, MINN, MAXP, MINN, 0), 1, e);
		// floor, wall and a far box in the last slot
		add_row(ROW_LOAD, mk_load(0, 0, 10 * Q1, 20 * Q1, 4 * Q1, 1), 0, none);
		add_row(ROW_LOAD, mk_load(1, 30 * Q1, 0, 4 * Q1, 20 * Q1, 2), 0, none);
		add_row(ROW_LOAD, mk_load(63, -100 * Q1, -100 * Q1, 1, 1, 3), 0, none);
		add_cfg(CFG_COUNT, 31'd2);
		add_cfg(CFG_GRAVITY, 31'(10 * Q1));
		add_cfg(CFG_FRICTION, 31'(Q1));
		add_cfg(CFG_DRAG, 31'd1000);
		// landing on the floor, slow slide clamps to zero by friction
		add_row(ROW_MOVE, mk_move(2 * Q1, 7 * Q1, 2 * Q1, 4 * Q1, 9, Q1 / 4, 3 * Q1, 0, 0,
			16'hffff), 0, none);
		// landing with a fast slide, friction only slows it
		add_row(ROW_MOVE, mk_move(2 * Q1, 7 * Q1, 2 * Q1, 4 * Q1, 9, -5 * Q1, 3 * Q1, Q1, Q1,
			16'h8000), 0, none);
		// same tag as the floor, so it falls through
		add_row(ROW_MOVE, mk_move(2 * Q1, 7 * Q1, 2 * Q1, 4 * Q1, 1, Q1 / 4, 3 * Q1, 0, 0,
			16'hffff), 0, none);
		// half unit into the wall, pushed left on x
		add_row(ROW_MOVE, mk_move(28 * Q1 + Q1 / 2, 2 * Q1, 2 * Q1, 2 * Q1, 9, 2 * Q1, 0, Q1, Q1,
			1000), 0, none);
		// under the floor, pushed down, not grounded
		add_row(ROW_MOVE, mk_move(5 * Q1, 13 * Q1 + Q1 / 2, 2 * Q1, 2 * Q1, 9, 0, -Q1, 0, 0,
			500), 0, none);
		// just touching the floor top, no push
		add_row(ROW_MOVE, mk_move(5 * Q1, 6 * Q1, 2 * Q1, 4 * Q1, 9, 0, 0, 0, 0, 500), 0, none);
		// corner with equal overlaps picks y
		add_row(ROW_MOVE, mk_move(19 * Q1, 9 * Q1, 2 * Q1, 2 * Q1, 9, Q1, Q1, 0, 0, 100), 0, none);
		// one-lsb overlap into the floor top, pushed up by one lsb
		add_row(ROW_MOVE, mk_move(2 * Q1, 6 * Q1 + 1, 2 * Q1, 4 * Q1, 9, 0, 0, 0, 0, 0), 0, none);
		// saturating velocities while grounded
		add_row(ROW_MOVE, mk_move(2 * Q1, 7 * Q1, 2 * Q1, 4 * Q1, 9, MAXP, MINN, MAXP, MINN,
			16'hffff), 0, none);
		add_cfg(CFG_DRAG, 31'h0ffff);
		add_cfg(CFG_FRICTION, 31'(MAXP));
		add_row(ROW_MOVE, mk_move(2 * Q1, 7 * Q1, 2 * Q1, 4 * Q1, 9, MINN, MAXP, MINN, MAXP,
			16'hffff), 0, none);

		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].rk == ROW_CFG) begin
				drain_idle();
				cfg_wr_en <= 1; cfg_index <= rows[i].cfg_idx; cfg_data <= rows[i].cfg_val;
				@(posedge clk);
				model_reg(rows[i].cfg_idx, rows[i].cfg_val);
				cfg_wr_en <= 0;
			end else begin
				send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
			end
		end

		// random phases, each with its own globals, placement and idling
		for (int ph = 0; ph < 8; ph++) begin
			drain_idle();
			case (ph % 4)
			0: begin
				g = '0; d = '0; f = '0; c = 31'd64;
			end
			1: begin
				g = 31'(MAXP); d = 31'h0ffff; f = 31'(MAXP); c = 31'd127;
			end
			2: begin
				g = 31'($urandom_range(0, 20 * Q1)); d = 31'($urandom_range(0, 8000));
				f = 31'($urandom_range(0, 4 * Q1)); c = 31'($urandom_range(1, 64));
			end
			default: begin
				g = 31'($urandom); d = 31'($urandom); f = 31'($urandom);
				c = 31'($urandom_range(0, 127));
			end
			endcase
			// stray upper bits on the narrow registers
			if (ph >= 4) begin
				d[30:16] = 15'($urandom);
				c[30:7] = 24'($urandom);
			end
			if (ph == 0)
				c[6:0] = '0; // only slots 0, 1 and 63 loaded so far
			write_globals(g, d, f, c);
			stall_mode = ph % 3;
			bursty = (ph % 4) != 3;
			case (ph % 3)
			0: begin
				cx = 0; cy = 0;
			end
			1: begin
				cx = 32'h7ff00000; cy = 32'h7ff00000;
			end
			default: begin
				cx = 32'h80100000; cy = $urandom;
			end
			endcase
			// first phase fills the whole table, later ones refresh part of it
			if (ph == 0) begin
				for (int s = 0; s < MAX_COLLIDERS; s++)
					send_request(rand_collider(s, cx, cy), 0, none);
				drain_idle();
				write_globals(g, d, f, 31'd64);
			end else begin
				for (int k = 0; k < 16; k++)
					send_request(rand_collider($urandom_range(0, 63), cx, cy), 0, none);
			end
			for (int k = 0; k < 80; k++) begin
				if ($urandom_range(0, 9) == 0)
					r = rand_collider($urandom_range(0, 63), cx, cy);
				else
					r = rand_mover(cx, cy);
				send_request(r, 0, none);
			end
		end

		drain_idle();
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
